>>> rtl/pisd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisd_pkg: shared types and constants for the packed integer stream decoder
// Payload structs, decoder state and the escape and length codes of both
// packed forms.
// ----------------------------------------------------------------------------
package pisd_pkg;

	localparam int ValueW = 32;
	localparam int CountW = 3;

	// Form codes, sampled from the mode bit on the first byte of a value
	localparam logic FORM_COMPACT = 1'b0;
	localparam logic FORM_SEVEN   = 1'b1;

	// Compact form escape bytes
	localparam logic [7:0] ESC_16 = 8'h80;
	localparam logic [7:0] ESC_32 = 8'h81;

	// Value lengths in bytes
	localparam logic [CountW-1:0] LEN_ONE  = 3'd1;
	localparam logic [CountW-1:0] LEN_16   = 3'd3;
	localparam logic [CountW-1:0] LEN_32   = 3'd5;
	localparam logic [CountW-1:0] LEN_SEVEN = 3'd4;

	localparam logic [ValueW-1:0] SIGN_FILL = 32'hF000_0000;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       mode;
	} in_t;

	typedef struct packed {
		logic signed [ValueW-1:0] value;
		logic [CountW-1:0]        byte_count;
	} out_t;

	typedef struct packed {
		logic              active_form;
		logic [CountW-1:0] bytes_taken;
		logic [CountW-1:0] bytes_expected;
		logic [ValueW-1:0] partial_value;
	} state_t;

endpackage

>>> rtl/pisd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisd_step: one-byte decode step
// Merges one stream byte into the accumulator and forms the result when the
// byte completes a value.
// ----------------------------------------------------------------------------
module pisd_step (
	input  pisd_pkg::state_t cur,
	input  pisd_pkg::in_t    item,
	output pisd_pkg::state_t nxt,
	output logic             emit,
	output pisd_pkg::out_t   res
);

	logic [7:0]                     b;
	logic [pisd_pkg::ValueW-1:0]    placed8;
	logic [pisd_pkg::ValueW-1:0]    placed7;
	logic [pisd_pkg::ValueW-1:0]    placed7_full;
	logic [pisd_pkg::ValueW-1:0]    merged;
	logic [pisd_pkg::ValueW-1:0]    sev_val;
	logic [pisd_pkg::CountW-1:0]    bt_inc;
	logic [1:0]                     k;
	logic                           last;

	assign b      = item.byte_in;
	assign bt_inc = cur.bytes_taken + 3'd1;
	assign k      = cur.bytes_taken[1:0];
	assign last   = (k == 2'd3) || !b[7];

	// Compact form: byte lanes, low byte first
	always_comb begin
		placed8 = '0;
		case (cur.bytes_taken[1:0] - 2'd1)
			2'd0:    placed8 = {24'd0, b};
			2'd1:    placed8 = {16'd0, b, 8'd0};
			2'd2:    placed8 = {8'd0, b, 16'd0};
			2'd3:    placed8 = {b, 24'd0};
			default: placed8 = '0;
		endcase
	end

	// Seven-bit form: groups at 7, 14, 21; the full byte lands at 21 on the fourth byte
	always_comb begin
		placed7      = '0;
		placed7_full = '0;
		case (k)
			2'd1: begin
				placed7      = {18'd0, b[6:0], 7'd0};
				placed7_full = {17'd0, b, 7'd0};
			end
			2'd2: begin
				placed7      = {11'd0, b[6:0], 14'd0};
				placed7_full = {10'd0, b, 14'd0};
			end
			2'd3: begin
				placed7      = {4'd0, b[6:0], 21'd0};
				placed7_full = {3'd0, b, 21'd0};
			end
			default: begin
				placed7      = {25'd0, b[6:0]};
				placed7_full = {24'd0, b};
			end
		endcase
	end

	assign merged  = cur.partial_value | placed8;
	assign sev_val = (cur.partial_value | placed7_full) |
		((cur.partial_value[28] | placed7_full[28]) ? pisd_pkg::SIGN_FILL : '0);

	always_comb begin
		nxt            = cur;
		emit           = 1'b0;
		res.value      = '0;
		res.byte_count = '0;
		if (cur.bytes_taken == '0) begin
			nxt.active_form   = item.mode;
			nxt.partial_value = '0;
			if (item.mode == pisd_pkg::FORM_COMPACT) begin
				if (b == pisd_pkg::ESC_16 || b == pisd_pkg::ESC_32) begin
					nxt.bytes_taken    = 3'd1;
					nxt.bytes_expected = (b == pisd_pkg::ESC_16) ?
						pisd_pkg::LEN_16 : pisd_pkg::LEN_32;
				end else begin
					emit           = 1'b1;
					res.value      = {{24{b[7]}}, b};
					res.byte_count = pisd_pkg::LEN_ONE;
				end
			end else if (!b[7]) begin
				emit           = 1'b1;
				res.value      = {24'd0, b};
				res.byte_count = pisd_pkg::LEN_ONE;
			end else begin
				nxt.partial_value  = {25'd0, b[6:0]};
				nxt.bytes_taken    = 3'd1;
				nxt.bytes_expected = pisd_pkg::LEN_SEVEN;
			end
		end else if (cur.active_form == pisd_pkg::FORM_COMPACT) begin
			if (bt_inc >= cur.bytes_expected) begin
				emit           = 1'b1;
				res.byte_count = bt_inc;
				res.value      = (bt_inc == pisd_pkg::LEN_16) ?
					{{16{merged[15]}}, merged[15:0]} : merged;
			end else begin
				nxt.partial_value = merged;
				nxt.bytes_taken   = bt_inc;
			end
		end else begin
			if (last) begin
				emit           = 1'b1;
				res.value      = sev_val;
				res.byte_count = {1'b0, k} + 3'd1;
			end else begin
				nxt.partial_value = cur.partial_value | placed7;
				nxt.bytes_taken   = bt_inc;
			end
		end
		// A finished value returns the decoder to idle
		if (emit) begin
			nxt = '0;
		end
	end

endmodule

>>> rtl/packed_int_stream_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_int_stream_decoder_top: packed integer stream decoder
// Rebuilds 32-bit integers from a byte stream in compact signed form or
// seven-bit continuation form, one byte per transaction.
// ----------------------------------------------------------------------------
// A result transaction appears in the cycle after its last byte is taken.
// Throughput: one byte per cycle while in_ready is high; the accumulator updates in a single step.
// The result register frees each cycle it is drained, so input stalls only
// while a result waits on out_ready.
// Reset: arst_n clears the accumulator to idle and drops out_valid.
module packed_int_stream_decoder_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pisd_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output pisd_pkg::out_t out_data
);

	pisd_pkg::state_t st_q;
	pisd_pkg::state_t st_nxt;
	pisd_pkg::out_t   res;
	pisd_pkg::out_t   out_data_q;
	logic             emit;
	logic             out_valid_q;
	logic             in_acc;

	// Accept a new byte whenever the result register is empty or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	pisd_step u_step (
		.cur  (st_q),
		.item (in_data),
		.nxt  (st_nxt),
		.emit (emit),
		.res  (res)
	);

	// Advance the accumulator only on an accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_acc) begin
			st_q <= st_nxt;
		end
	end

	// Result register: load on a completing byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the payload until the next completing byte
	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A value in progress never holds more than four bytes
	a_taken_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bytes_taken <= 3'd4)
		else $error("bytes_taken out of range");

	// Seven-bit form always ends by the fourth byte
	a_seven_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.active_form == pisd_pkg::FORM_SEVEN) |-> st_q.bytes_taken <= 3'd3)
		else $error("seven-bit value ran past its fourth byte");

	// A completing byte leaves the decoder idle with a result pending
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && emit) |=> (st_q.bytes_taken == '0) && out_valid_q)
		else $error("decoder not idle after a completed value");

	// Every result covers one to five bytes
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.byte_count >= 3'd1) && (out_data_q.byte_count <= 3'd5))
		else $error("byte_count out of range");

endmodule

>>> verif/pisd_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisd_stream_checker: scoreboard for the packed integer stream decoder
// Watches both channels, rebuilds each value from the accepted bytes and
// compares every result transaction against the oldest predicted value.
// ----------------------------------------------------------------------------
module pisd_stream_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  pisd_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  pisd_pkg::out_t out_data,
	output int             fail_count,
	output int             pending
);

	// Shadow of the decoder accumulator
	logic                        form_q;
	logic [pisd_pkg::CountW-1:0] taken_q;
	logic [pisd_pkg::CountW-1:0] len_q;
	logic [pisd_pkg::ValueW-1:0] acc_q;

	pisd_pkg::out_t decoded_values[$];

	// Fold one byte into the shadow accumulator; return 1 when a value completes.
	function automatic bit decode_byte(input pisd_pkg::in_t item,
		output pisd_pkg::out_t res);
		logic [7:0]                  b;
		logic [pisd_pkg::ValueW-1:0] v;
		logic [1:0]                  k;
		logic [4:0]                  sh;
		bit                          done;
		b    = item.byte_in;
		res  = '0;
		done = 1'b0;
		if (taken_q == '0) begin
			form_q = item.mode;
			acc_q  = '0;
			if (item.mode == pisd_pkg::FORM_COMPACT) begin
				if (b == pisd_pkg::ESC_16 || b == pisd_pkg::ESC_32) begin
					taken_q = 3'd1;
					len_q   = (b == pisd_pkg::ESC_16) ?
						pisd_pkg::LEN_16 : pisd_pkg::LEN_32;
				end else begin
					res.value      = {{24{b[7]}}, b};
					res.byte_count = pisd_pkg::LEN_ONE;
					done           = 1'b1;
				end
			end else if (!b[7]) begin
				res.value      = {24'b0, b};
				res.byte_count = pisd_pkg::LEN_ONE;
				done           = 1'b1;
			end else begin
				acc_q   = {25'b0, b[6:0]};
				taken_q = 3'd1;
				len_q   = pisd_pkg::LEN_SEVEN;
			end
		end else if (form_q == pisd_pkg::FORM_COMPACT) begin
			// little-endian bytes after the escape
			k       = 2'(taken_q - 3'd1);
			sh      = {k, 3'b000};
			acc_q   = acc_q | ({24'b0, b} << sh);
			taken_q = taken_q + 3'd1;
			if (taken_q >= len_q) begin
				v = acc_q;
				if (taken_q == pisd_pkg::LEN_16)
					v = {{16{v[15]}}, v[15:0]};
				res.value      = v;
				res.byte_count = taken_q;
				done           = 1'b1;
			end
		end else begin
			k  = taken_q[1:0];
			sh = 5'(7 * k);
			// the fourth byte is all payload and always ends the value
			if (taken_q != pisd_pkg::LEN_SEVEN - 3'd1 && b[7]) begin
				acc_q   = acc_q + ({25'b0, b[6:0]} << sh);
				taken_q = taken_q + 3'd1;
			end else begin
				v = acc_q + ({24'b0, b} << sh);
				if (v[28])
					v = v | pisd_pkg::SIGN_FILL;
				res.value      = v;
				res.byte_count = {1'b0, k} + 3'd1;
				done           = 1'b1;
			end
		end
		if (done) begin
			form_q  = pisd_pkg::FORM_COMPACT;
			taken_q = '0;
			len_q   = '0;
			acc_q   = '0;
		end
		return done;
	endfunction

	initial begin
		fail_count = 0;
		pending    = 0;
		form_q     = pisd_pkg::FORM_COMPACT;
		taken_q    = '0;
		len_q      = '0;
		acc_q      = '0;
	end

	always @(posedge clk or negedge arst_n) begin
		pisd_pkg::out_t want;
		pisd_pkg::out_t got;
		if (!arst_n) begin
			form_q  = pisd_pkg::FORM_COMPACT;
			taken_q = '0;
			len_q   = '0;
			acc_q   = '0;
			decoded_values.delete();
		end else begin
			// predict first, so a same-edge result still finds its entry
			if (in_valid && in_ready) begin
				if (decode_byte(in_data, want))
					decoded_values.push_back(want);
			end
			if (out_valid && out_ready) begin
				got = out_data;
				if (decoded_values.size() == 0) begin
					$display("%0t: unexpected result: expected none, got value %0d count %0d",
						$time, $signed(got.value), got.byte_count);
					fail_count++;
				end else begin
					want = decoded_values.pop_front();
					if (got.value !== want.value) begin
						$display("%0t: value mismatch: expected %0d (%h), got %0d (%h)",
							$time, $signed(want.value), want.value,
							$signed(got.value), got.value);
						fail_count++;
					end
					if (got.byte_count !== want.byte_count) begin
						$display("%0t: byte_count mismatch: expected %0d, got %0d",
							$time, want.byte_count, got.byte_count);
						fail_count++;
					end
				end
			end
		end
		pending = decoded_values.size();
	end

endmodule

>>> verif/packed_int_stream_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_int_stream_decoder_top_tb: stimulus and verdict for the decoder
// Feeds directed and random byte streams in both packed forms with random
// gaps and back-pressure; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module packed_int_stream_decoder_top_tb;

	localparam int RandomBytes = 1750;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	pisd_pkg::in_t  in_data;
	logic           out_valid;
	logic           out_ready;
	pisd_pkg::out_t out_data;

	int fail_count;
	int pending;

	// Sender gap control; cleared for a stretch to run back to back
	bit tx_gaps_on;
	int bytes_sent;

	packed_int_stream_decoder_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	pisd_stream_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one byte: drive at the falling edge, possibly after some idle
	// cycles, then hold valid and payload until the transaction is taken.
	task automatic send_byte(input logic [7:0] b, input logic m);
		pisd_pkg::in_t item;
		item.byte_in = b;
		item.mode    = m;
		@(negedge clk);
		while (tx_gaps_on && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Send one random value. Mostly well-formed sequences with random
	// payload; continuation bytes carry a random mode bit, which the block
	// must ignore. A small share is raw noise.
	task automatic send_random_value();
		int          kind;
		int          n;
		logic [7:0]  b;
		kind = $urandom_range(99);
		if (kind < 8) begin
			send_byte(8'($urandom), 1'($urandom));
		end else if (kind < 50) begin
			case ($urandom_range(2))
				0: send_byte(8'($urandom), pisd_pkg::FORM_COMPACT);
				1: begin
					send_byte(pisd_pkg::ESC_16, pisd_pkg::FORM_COMPACT);
					repeat (2) send_byte(8'($urandom), 1'($urandom));
				end
				default: begin
					send_byte(pisd_pkg::ESC_32, pisd_pkg::FORM_COMPACT);
					repeat (4) send_byte(8'($urandom), 1'($urandom));
				end
			endcase
		end else begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				b = 8'($urandom);
				// continuation on all but the last; the fourth byte keeps bit 7
				if (i < n - 1)
					b[7] = 1'b1;
				else if (i < 3)
					b[7] = 1'b0;
				send_byte(b, (i == 0) ? pisd_pkg::FORM_SEVEN : 1'($urandom));
			end
		end
	endtask

	// Receiver: random stalls, two long hold-offs while the sender keeps
	// offering (fills the result register and stalls the input), and one
	// stretch with out_ready held high.
	initial begin
		int cyc;
		int hold;
		out_ready = 1'b0;
		cyc  = 0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == 300 || cyc == 1500)
				hold = 250;
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else if (cyc >= 2200 && cyc < 2700) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 31);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		in_valid   = 1'b0;
		in_data    = '0;
		arst_n     = 1'b0;
		tx_gaps_on = 1'b1;
		bytes_sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Compact form: plain bytes at the sign boundaries
		send_byte(8'h00, pisd_pkg::FORM_COMPACT);
		send_byte(8'h7F, pisd_pkg::FORM_COMPACT);
		send_byte(8'hFF, pisd_pkg::FORM_COMPACT);
		send_byte(8'h82, pisd_pkg::FORM_COMPACT);
		// 16-bit escape: most negative, then most positive with the mode
		// bit flipped mid-value (must be ignored)
		send_byte(pisd_pkg::ESC_16, pisd_pkg::FORM_COMPACT);
		send_byte(8'h00, pisd_pkg::FORM_COMPACT);
		send_byte(8'h80, pisd_pkg::FORM_COMPACT);
		send_byte(pisd_pkg::ESC_16, pisd_pkg::FORM_COMPACT);
		send_byte(8'hFF, pisd_pkg::FORM_SEVEN);
		send_byte(8'h7F, pisd_pkg::FORM_SEVEN);
		// 32-bit escape: most negative 32-bit value
		send_byte(pisd_pkg::ESC_32, pisd_pkg::FORM_COMPACT);
		send_byte(8'h00, pisd_pkg::FORM_COMPACT);
		send_byte(8'h00, pisd_pkg::FORM_SEVEN);
		send_byte(8'h00, pisd_pkg::FORM_COMPACT);
		send_byte(8'h80, pisd_pkg::FORM_SEVEN);
		// Seven-bit form: one, two and three bytes
		send_byte(8'h7F, pisd_pkg::FORM_SEVEN);
		send_byte(8'h80, pisd_pkg::FORM_SEVEN);
		send_byte(8'h00, pisd_pkg::FORM_SEVEN);
		send_byte(8'hFF, pisd_pkg::FORM_SEVEN);
		send_byte(8'hFF, pisd_pkg::FORM_COMPACT);
		send_byte(8'h7F, pisd_pkg::FORM_SEVEN);
		// Fourth byte carries all eight bits and sets bit 28: sign fill
		send_byte(8'hFF, pisd_pkg::FORM_SEVEN);
		send_byte(8'hFF, pisd_pkg::FORM_SEVEN);
		send_byte(8'hFF, pisd_pkg::FORM_COMPACT);
		send_byte(8'hFF, pisd_pkg::FORM_SEVEN);

		// Random part; a window of back-to-back bytes in the middle
		bytes_sent = 0;
		while (bytes_sent < RandomBytes) begin
			tx_gaps_on = !(bytes_sent >= 400 && bytes_sent < 700);
			send_random_value();
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// Drain: wait for every predicted value, then a few more cycles
		// so a stray extra result is still caught.
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("packed_int_stream_decoder_top_tb: PASS");
		else
			$display("packed_int_stream_decoder_top_tb: FAIL");
		$finish;
	end

	// Hang guard
	initial begin
		#2_000_000;
		$display("packed_int_stream_decoder_top_tb: FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/pisd_pkg.sv
rtl/pisd_step.sv
rtl/packed_int_stream_decoder_top.sv
verif/pisd_stream_checker.sv
verif/packed_int_stream_decoder_top_tb.sv
